// ===== rtl/oss_pkg.sv =====
package oss_pkg;

    // Width of time stamps and ages; stamps and ages wrap modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;

    localparam int NOW_W     = 32;
    localparam int RANGE_W   = 10;
    localparam int HEAD_W    = 16;
    localparam int SPEED_W   = 8;
    localparam int STEP_W    = 4;
    localparam int PERIOD_W  = 16;
    localparam int TURN_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef logic [TIME_BITS-1:0] t_time;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP        = 3'd4;

    // Register values after reset
    localparam logic [RANGE_W-1:0]  RST_CLEAR_DISTANCE   = 10'd15;
    localparam logic [SPEED_W-1:0]  RST_CRUISE_SPEED     = 8'd20;
    localparam logic [PERIOD_W-1:0] RST_DWELL_MS         = 16'd1500;
    localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD_MS = 16'd20;
    localparam logic [TURN_W-1:0]   RST_TURN_STEP        = 8'd90;

    // Scan steps
    localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LEFT_TURNED = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LEFT_SAMPLE = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LEFT_BACK   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LEFT_PAUSE  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RIGHT_TURN  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RIGHT_SAMP  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_RIGHT_BACK  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CHOOSE      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FINISH      = 4'd9;

    typedef struct packed {
        logic [RANGE_W-1:0]  clear_distance;
        logic [SPEED_W-1:0]  cruise_speed;
        logic [PERIOD_W-1:0] dwell_ms;
        logic [PERIOD_W-1:0] sample_period_ms;
        logic [TURN_W-1:0]   turn_step;
    } t_cfg;

    typedef struct packed {
        logic [SPEED_W-1:0]       speed_cmd;
        logic signed [HEAD_W-1:0] target_heading;
        logic                     avoiding;
        logic [STEP_W-1:0]        scan_step;
    } t_result;

endpackage

// ===== rtl/oss_ctrl.sv =====
module oss_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic [oss_pkg::NOW_W-1:0]        i_now_ms,
    input  logic [oss_pkg::RANGE_W-1:0]      i_range_cm,
    input  logic signed [oss_pkg::HEAD_W-1:0] i_heading,
    input  oss_pkg::t_cfg                    i_cfg,
    output oss_pkg::t_result                 o_res
);

    logic                          r_avoid_mode,    n_avoid_mode;
    logic [oss_pkg::STEP_W-1:0]    r_step_index,    n_step_index;
    oss_pkg::t_time                r_step_start_ms, n_step_start_ms;
    oss_pkg::t_time                r_sample_time_ms, n_sample_time_ms;
    logic [oss_pkg::RANGE_W-1:0]   r_held_range,    n_held_range;
    logic [oss_pkg::RANGE_W-1:0]   r_left_range,    n_left_range;
    logic [oss_pkg::RANGE_W-1:0]   r_right_range,   n_right_range;
    logic [oss_pkg::HEAD_W-1:0]    r_goal_heading,  n_goal_heading;
    logic [oss_pkg::SPEED_W-1:0]   r_speed_reg,     n_speed_reg;

    oss_pkg::t_time              now_t;
    oss_pkg::t_time              sample_age;
    oss_pkg::t_time              step_age;
    logic                        sample_due;
    logic                        step_due;
    logic [oss_pkg::HEAD_W-1:0]  goal_right;
    logic [oss_pkg::HEAD_W-1:0]  goal_left;

    // Ages, modulo the time width
    assign now_t      = oss_pkg::t_time'(i_now_ms);
    assign sample_age = now_t - r_sample_time_ms;
    assign step_age   = now_t - r_step_start_ms;
    assign sample_due = sample_age > oss_pkg::t_time'(i_cfg.sample_period_ms);
    assign step_due   = step_age > oss_pkg::t_time'(i_cfg.dwell_ms);

    // Turned headings, wrapping at 16 bits
    assign goal_right = r_goal_heading + oss_pkg::HEAD_W'(i_cfg.turn_step);
    assign goal_left  = r_goal_heading - oss_pkg::HEAD_W'(i_cfg.turn_step);

    // Next state for one item
    always_comb begin
        n_avoid_mode     = r_avoid_mode;
        n_step_index     = r_step_index;
        n_step_start_ms  = r_step_start_ms;
        n_sample_time_ms = r_sample_time_ms;
        n_held_range     = r_held_range;
        n_left_range     = r_left_range;
        n_right_range    = r_right_range;
        n_goal_heading   = r_goal_heading;
        n_speed_reg      = r_speed_reg;

        if (sample_due) begin
            n_held_range     = i_range_cm;
            n_sample_time_ms = now_t;
        end

        if (!r_avoid_mode) begin
            if (n_held_range > i_cfg.clear_distance) begin
                n_speed_reg    = i_cfg.cruise_speed;
                n_goal_heading = i_heading;
            end else begin
                n_avoid_mode = 1'b1;
                n_speed_reg  = '0;
            end
        end else if (r_step_index == oss_pkg::STEP_IDLE) begin
            n_goal_heading  = goal_left;
            n_step_index    = oss_pkg::STEP_LEFT_TURNED;
            n_step_start_ms = now_t;
        end else if (step_due) begin
            n_step_index    = r_step_index + 1'b1;
            n_step_start_ms = now_t;
            case (r_step_index)
                oss_pkg::STEP_LEFT_TURNED: n_left_range   = i_range_cm;
                oss_pkg::STEP_LEFT_SAMPLE: n_goal_heading = goal_right;
                oss_pkg::STEP_LEFT_BACK:   ;
                oss_pkg::STEP_LEFT_PAUSE:  n_goal_heading = goal_right;
                oss_pkg::STEP_RIGHT_TURN:  n_right_range  = i_range_cm;
                oss_pkg::STEP_RIGHT_SAMP:  n_goal_heading = goal_left;
                oss_pkg::STEP_RIGHT_BACK:  ;
                oss_pkg::STEP_CHOOSE: begin
                    // equal ranges go right
                    n_goal_heading = (r_left_range > r_right_range) ? goal_left
                                                                    : goal_right;
                end
                default: begin
                    // finish, also for any out-of-range step
                    n_speed_reg     = i_cfg.cruise_speed;
                    n_step_index    = oss_pkg::STEP_IDLE;
                    n_avoid_mode    = 1'b0;
                    n_step_start_ms = r_step_start_ms;
                end
            endcase
        end
    end

    // State update, one item per transfer out of the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avoid_mode     <= 1'b0;
            r_step_index     <= oss_pkg::STEP_IDLE;
            r_step_start_ms  <= '0;
            r_sample_time_ms <= '0;
            r_held_range     <= '0;
            r_left_range     <= '0;
            r_right_range    <= '0;
            r_goal_heading   <= '0;
            r_speed_reg      <= '0;
        end else if (i_adv) begin
            r_avoid_mode     <= n_avoid_mode;
            r_step_index     <= n_step_index;
            r_step_start_ms  <= n_step_start_ms;
            r_sample_time_ms <= n_sample_time_ms;
            r_held_range     <= n_held_range;
            r_left_range     <= n_left_range;
            r_right_range    <= n_right_range;
            r_goal_heading   <= n_goal_heading;
            r_speed_reg      <= n_speed_reg;
        end
    end

    // The state registers are the result register
    assign o_res.speed_cmd      = r_speed_reg;
    assign o_res.target_heading = r_goal_heading;
    assign o_res.avoiding       = r_avoid_mode;
    assign o_res.scan_step      = r_step_index;

endmodule

// ===== rtl/obstacle_scan_sequencer.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_now_ms, i_range_cm, i_heading
// out       output     o_out_valid / i_out_stall  o_speed_cmd, o_target_heading,
//                                                 o_avoiding, o_scan_step
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. The result
// passes through the input register, then the state/result register, before
// it shows at the output.
// Synchronous active-low reset clears the pipeline and all state and loads
// the register defaults. A stalled output holds the result and, once the
// input register is also full, stalls the input.
module obstacle_scan_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [oss_pkg::NOW_W-1:0]          i_now_ms,
    input  logic [oss_pkg::RANGE_W-1:0]        i_range_cm,
    input  logic signed [oss_pkg::HEAD_W-1:0]  i_heading,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [oss_pkg::SPEED_W-1:0]        o_speed_cmd,
    output logic signed [oss_pkg::HEAD_W-1:0]  o_target_heading,
    output logic                               o_avoiding,
    output logic [oss_pkg::STEP_W-1:0]         o_scan_step,
    input  logic                               i_cfg_we,
    input  logic [oss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [oss_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    oss_pkg::t_cfg                       r_cfg;
    logic                                r_s1_vld;
    logic [oss_pkg::NOW_W-1:0]           r_s1_now;
    logic [oss_pkg::RANGE_W-1:0]         r_s1_range;
    logic signed [oss_pkg::HEAD_W-1:0]   r_s1_head;
    logic                                r_out_vld;

    logic             out_free;
    logic             s1_adv;
    logic             in_xfer;
    oss_pkg::t_result res;

    // Handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_distance   <= oss_pkg::RST_CLEAR_DISTANCE;
            r_cfg.cruise_speed     <= oss_pkg::RST_CRUISE_SPEED;
            r_cfg.dwell_ms         <= oss_pkg::RST_DWELL_MS;
            r_cfg.sample_period_ms <= oss_pkg::RST_SAMPLE_PERIOD_MS;
            r_cfg.turn_step        <= oss_pkg::RST_TURN_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                oss_pkg::CFG_CLEAR_DISTANCE:
                    r_cfg.clear_distance <= i_cfg_data[oss_pkg::RANGE_W-1:0];
                oss_pkg::CFG_CRUISE_SPEED:
                    r_cfg.cruise_speed <= i_cfg_data[oss_pkg::SPEED_W-1:0];
                oss_pkg::CFG_DWELL_MS:
                    r_cfg.dwell_ms <= i_cfg_data[oss_pkg::PERIOD_W-1:0];
                oss_pkg::CFG_SAMPLE_PERIOD_MS:
                    r_cfg.sample_period_ms <= i_cfg_data[oss_pkg::PERIOD_W-1:0];
                oss_pkg::CFG_TURN_STEP:
                    r_cfg.turn_step <= i_cfg_data[oss_pkg::TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_now   <= i_now_ms;
            r_s1_range <= i_range_cm;
            r_s1_head  <= i_heading;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Sequencer state and result
    oss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s1_adv),
        .i_now_ms   (r_s1_now),
        .i_range_cm (r_s1_range),
        .i_heading  (r_s1_head),
        .i_cfg      (r_cfg),
        .o_res      (res)
    );

    assign o_out_valid      = r_out_vld;
    assign o_speed_cmd      = res.speed_cmd;
    assign o_target_heading = res.target_heading;
    assign o_avoiding       = res.avoiding;
    assign o_scan_step      = res.scan_step;

endmodule

// ===== rtl/oss_checker.sv =====
module oss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [oss_pkg::SPEED_W-1:0]        o_speed_cmd,
    input logic signed [oss_pkg::HEAD_W-1:0]  o_target_heading,
    input logic                               o_avoiding,
    input logic [oss_pkg::STEP_W-1:0]         o_scan_step
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_speed_cmd)
            && $stable(o_target_heading) && $stable(o_avoiding) && $stable(o_scan_step))
        else $error("result changed while stalled");

    // Input is only stalled behind a blocked result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // A scan step is only shown while avoiding
    a_step_avoid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scan_step != oss_pkg::STEP_IDLE |-> o_avoiding)
        else $error("scan step outside avoid mode");

    // Stopped throughout the scan
    a_avoid_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_avoiding |-> o_speed_cmd == '0)
        else $error("moving while avoiding");

endmodule

bind obstacle_scan_sequencer oss_checker u_oss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_speed_cmd      (o_speed_cmd),
    .o_target_heading (o_target_heading),
    .o_avoiding       (o_avoiding),
    .o_scan_step      (o_scan_step)
);
